// File: hw/rtl/ntcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// NTC temperature filter package
// Shared constants, payload types and the elaboration-time build of the
// thermistor conversion table.
// ============================================================================
package ntcf_pkg;

    localparam int NUM_CHANNELS        = 4;
    localparam int SAMPLES_PER_READING = 4;
    localparam int ADC_BITS            = 10;

    localparam int ROM_DEPTH  = 1 << ADC_BITS;
    localparam int ROM_WORD_W = 17;
    localparam int CH_IDX_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);

    // Configuration register indexes.
    localparam logic [1:0] CFG_TEMP_MIN = 2'd0;
    localparam logic [1:0] CFG_TEMP_MAX = 2'd1;
    localparam logic [1:0] CFG_MAX_STEP = 2'd2;

    // Result status codes.
    localparam logic [1:0] STATUS_NEW  = 2'd0;
    localparam logic [1:0] STATUS_HELD = 2'd1;
    localparam logic [1:0] STATUS_NONE = 2'd2;

    localparam logic signed [15:0] TEMP_MIN_RST = -16'sd2000;
    localparam logic signed [15:0] TEMP_MAX_RST = 16'sd10000;
    localparam logic [14:0]        MAX_STEP_RST = 15'd1500;

    typedef struct packed {
        logic [1:0] chan;
        logic [9:0] sample_a;
        logic [9:0] sample_b;
        logic [9:0] sample_c;
        logic [9:0] sample_d;
    } t_in;

    typedef struct packed {
        logic [1:0]         chan_out;
        logic signed [15:0] temperature_centi;
        logic [1:0]         status;
    } t_out;

    typedef struct packed {
        logic signed [15:0] temp_min_centi;
        logic signed [15:0] temp_max_centi;
        logic [14:0]        max_step_centi;
    } t_cfg;

    // Classified reading passed from the front end to the filter.
    typedef struct packed {
        logic [1:0]         chan;
        logic               rom_ok;
        logic signed [15:0] rom_value;
    } t_work;

    typedef logic [ROM_DEPTH-1:0][ROM_WORD_W-1:0] t_rom_img;

    // log2 of x in Q28: integer part from the msb position, fraction by
    // repeated squaring of a Q30 mantissa.
    function automatic logic [63:0] log2_q28(input logic [63:0] x);
        logic [63:0] n;
        logic [63:0] m;
        logic [63:0] frac;
        n = 64'd0;
        for (int k = 0; k < 31; k++) begin
            if ((x >> (k + 1)) != 64'd0) begin
                n = 64'(k + 1);
            end
        end
        m = x << (64'd30 - n);
        frac = 64'd0;
        for (int i = 27; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                frac = frac | (64'd1 << i);
            end
        end
        return (n << 28) | frac;
    endfunction

    // Conversion table: bit 16 is the valid flag, bits 15:0 the temperature
    // in hundredths of a degree. The quotient is found by a bit-wise search.
    function automatic t_rom_img build_rom();
        t_rom_img           img;
        logic [63:0]        fs;
        logic [63:0]        a;
        logic [63:0]        hi;
        logic [63:0]        lo;
        logic [63:0]        diff;
        logic [63:0]        l28;
        logic [63:0]        l24;
        logic [63:0]        l2;
        logic [63:0]        l3;
        logic [63:0]        d;
        logic [63:0]        num;
        logic [63:0]        q;
        logic [63:0]        cand;
        logic signed [63:0] t;
        fs = 64'(ROM_DEPTH);
        for (int ai = 0; ai < ROM_DEPTH; ai++) begin
            a = 64'(ai);
            img[ai] = '0;
            if (!(a == 64'd0 || 64'd300 * a >= 64'd299 * fs || 64'd101 * a < fs)) begin
                hi = log2_q28(64'd10000 * a);
                lo = log2_q28(fs - a);
                if (hi > lo) begin
                    diff = hi - lo;
                    l28  = (diff * 64'd744261118) >> 30;
                    l24  = l28 >> 4;
                    l2   = (l24 * l24) >> 24;
                    l3   = (l2 * l24) >> 24;
                    d    = 64'd2775575000 + ((64'd248040000 * l28) >> 28)
                         + ((64'd490786 * l3) >> 24);
                    num  = 64'd200000000000000 + d;
                    q    = 64'd0;
                    for (int b = 20; b >= 0; b--) begin
                        cand = q | (64'd1 << b);
                        if (cand * (d << 1) <= num) begin
                            q = cand;
                        end
                    end
                    t = $signed(q) - 64'sd27315;
                    if (t >= -64'sd20000 && t <= 64'sd30000) begin
                        img[ai] = {1'b1, t[15:0]};
                    end
                end
            end
        end
        return img;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/ntcf_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// NTC filter front end
// Averages the samples of an item and looks the result up in the
// conversion table, registering the table word together with the channel.
// ============================================================================
module ntcf_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire ntcf_pkg::t_in  i_in,
    output logic                o_work_valid,
    input  wire logic           i_work_ready,
    output ntcf_pkg::t_work     o_work
);

    localparam int AW    = ntcf_pkg::ADC_BITS;
    localparam int SUM_W = AW + 2;
    localparam ntcf_pkg::t_rom_img RomImg = ntcf_pkg::build_rom();

    logic                                r_valid;
    logic [1:0]                          r_chan;
    logic [ntcf_pkg::ROM_WORD_W-1:0]     r_rom_q;
    logic [SUM_W-1:0]                    sum;
    logic [AW-1:0]                       idx;
    logic                                accept;

    // Only the first SAMPLES_PER_READING samples (at most four) count.
    always_comb begin
        sum = '0;
        if (ntcf_pkg::SAMPLES_PER_READING >= 1) sum = sum + SUM_W'(AW'(i_in.sample_a));
        if (ntcf_pkg::SAMPLES_PER_READING >= 2) sum = sum + SUM_W'(AW'(i_in.sample_b));
        if (ntcf_pkg::SAMPLES_PER_READING >= 3) sum = sum + SUM_W'(AW'(i_in.sample_c));
        if (ntcf_pkg::SAMPLES_PER_READING >= 4) sum = sum + SUM_W'(AW'(i_in.sample_d));
        idx = AW'(sum / ntcf_pkg::SAMPLES_PER_READING);
    end

    assign o_in_ready = !r_valid || i_work_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rom_q <= RomImg[idx];
            r_chan  <= i_in.chan;
        end
    end

    assign o_work_valid     = r_valid;
    assign o_work.chan      = r_chan;
    assign o_work.rom_ok    = r_rom_q[16];
    assign o_work.rom_value = $signed(r_rom_q[15:0]);

endmodule
`default_nettype wire

// File: hw/rtl/ntcf_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// NTC filter work queue
// Short FIFO that decouples the table lookup from the filter stage.
// ============================================================================
module ntcf_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push_valid,
    output logic                  o_push_ready,
    input  wire ntcf_pkg::t_work  i_push,
    output logic                  o_pop_valid,
    input  wire logic             i_pop_ready,
    output ntcf_pkg::t_work       o_pop
);

    localparam int PW = ntcf_pkg::QPTR_W;

    ntcf_pkg::t_work   r_mem [ntcf_pkg::QDEPTH];
    logic [PW-1:0]     r_wr_ptr;
    logic [PW-1:0]     r_rd_ptr;
    logic [PW:0]       r_count;
    logic [PW-1:0]     n_wr_ptr;
    logic [PW-1:0]     n_rd_ptr;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != (PW + 1)'(ntcf_pkg::QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop        = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == PW'(ntcf_pkg::QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PW'(ntcf_pkg::QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= n_wr_ptr;
            if (pop)  r_rd_ptr <= n_rd_ptr;
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/ntcf_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// NTC filter back end
// Clamps and slew-limits valid readings against per-channel history and
// registers the result item.
// ============================================================================
module ntcf_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ntcf_pkg::t_cfg   i_cfg,
    input  wire logic             i_work_valid,
    output logic                  o_work_ready,
    input  wire ntcf_pkg::t_work  i_work,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output ntcf_pkg::t_out        o_out
);

    localparam int CW = ntcf_pkg::CH_IDX_W;

    logic signed [15:0]          r_last_temp [ntcf_pkg::NUM_CHANNELS];
    logic [ntcf_pkg::NUM_CHANNELS-1:0] r_last_valid;
    logic                        r_out_valid;
    ntcf_pkg::t_out              r_out;
    ntcf_pkg::t_out              n_out;

    logic                        accept;
    logic                        chan_ok;
    logic [CW-1:0]               ch;
    logic                        have_prev;
    logic signed [17:0]          prev;
    logic signed [17:0]          step;
    logic signed [17:0]          rv;
    logic signed [17:0]          mn;
    logic signed [17:0]          mx;
    logic signed [17:0]          hi;
    logic signed [17:0]          lo;
    logic signed [17:0]          clamped;
    logic signed [17:0]          slewed;
    logic                        store;

    assign o_work_ready = !r_out_valid || i_out_ready;
    assign accept       = i_work_valid && o_work_ready;

    always_comb begin
        chan_ok   = ({3'b000, i_work.chan} < 5'(ntcf_pkg::NUM_CHANNELS));
        ch        = CW'(i_work.chan);
        have_prev = chan_ok && r_last_valid[ch];
        prev      = 18'(r_last_temp[ch]);
        step      = 18'($signed({1'b0, i_cfg.max_step_centi}));
        rv        = 18'(i_work.rom_value);
        mn        = 18'(i_cfg.temp_min_centi);
        mx        = 18'(i_cfg.temp_max_centi);
        hi        = prev + step;
        lo        = prev - step;

        // Below the lower bound, it wins even when the window is inverted.
        if (rv < mn) begin
            clamped = mn;
        end else if (rv > mx) begin
            clamped = mx;
        end else begin
            clamped = rv;
        end

        slewed = clamped;
        if (have_prev) begin
            if (clamped > hi) begin
                slewed = hi;
            end else if (clamped < lo) begin
                slewed = lo;
            end
        end

        store                   = chan_ok && i_work.rom_ok;
        n_out.chan_out          = i_work.chan;
        n_out.temperature_centi = '0;
        n_out.status            = ntcf_pkg::STATUS_NONE;
        if (store) begin
            n_out.temperature_centi = slewed[15:0];
            n_out.status            = ntcf_pkg::STATUS_NEW;
        end else if (have_prev) begin
            n_out.temperature_centi = r_last_temp[ch];
            n_out.status            = ntcf_pkg::STATUS_HELD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_last_valid <= '0;
        end else begin
            if (o_work_ready) begin
                r_out_valid <= i_work_valid;
            end
            if (accept && store) begin
                r_last_valid[ch] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
            if (store) begin
                r_last_temp[ch] <= slewed[15:0];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire

// File: hw/rtl/ntc_temperature_filter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted item is written to the table read register at the
// accepting edge, then to the queue, then to the filter output register,
// where its result item shows. Throughput: one item per cycle while the
// output is not stalled; the per-channel history update is a single
// read-modify-write in the filter stage, so back-to-back items on one channel
// do not stall. Reset (synchronous, active low) empties the pipeline, clears
// all channel history and restores the default clamp and step settings.
// ============================================================================
// NTC temperature filter unit
// Converts averaged thermistor ADC codes to hundredths of a degree, then
// clamps and slew-limits each channel's value against its history.
// ============================================================================
module ntc_temperature_filter_unit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    // Reading input channel.
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire ntcf_pkg::t_in  i_in,
    // Result output channel.
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output ntcf_pkg::t_out      o_out,
    // Configuration write port.
    input  wire logic           i_cfg_we,
    input  wire logic [1:0]     i_cfg_idx,
    input  wire logic [15:0]    i_cfg_data
);

    // The front end averages the samples and reads the conversion table.
    // Its registered table word goes into a two-entry queue, so the lookup
    // keeps accepting items while the filter waits on a stalled output.
    // The back end applies the window clamp, then limits the change against
    // the channel's stored value, and owns the output register.

    ntcf_pkg::t_cfg   r_cfg;
    logic             front_valid;
    logic             front_ready;
    ntcf_pkg::t_work  front_work;
    logic             queue_valid;
    logic             queue_ready;
    ntcf_pkg::t_work  queue_work;

    // Configuration registers. Writes must arrive only while the unit is idle;
    // the block does not enforce it, nor order them against items in flight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.temp_min_centi <= ntcf_pkg::TEMP_MIN_RST;
            r_cfg.temp_max_centi <= ntcf_pkg::TEMP_MAX_RST;
            r_cfg.max_step_centi <= ntcf_pkg::MAX_STEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ntcf_pkg::CFG_TEMP_MIN: r_cfg.temp_min_centi <= $signed(i_cfg_data);
                ntcf_pkg::CFG_TEMP_MAX: r_cfg.temp_max_centi <= $signed(i_cfg_data);
                ntcf_pkg::CFG_MAX_STEP: r_cfg.max_step_centi <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    ntcf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in         (i_in),
        .o_work_valid (front_valid),
        .i_work_ready (front_ready),
        .o_work       (front_work)
    );

    ntcf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push       (front_work),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (queue_ready),
        .o_pop        (queue_work)
    );

    ntcf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_work_valid (queue_valid),
        .o_work_ready (queue_ready),
        .i_work       (queue_work),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out        (o_out)
    );

endmodule
`default_nettype wire

// File: hw/rtl/ntcf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// NTC filter port checker
// Watches the top-level ports for reset, result coding and output stability.
// ============================================================================
module ntcf_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           o_out_valid,
    input wire logic           i_out_ready,
    input wire ntcf_pkg::t_out o_out
);

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A channel without history reports zero.
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == ntcf_pkg::STATUS_NONE)
            |-> (o_out.temperature_centi == 16'sd0))
        else $error("no-value result carries a nonzero temperature");

    // Stored and held values stay inside the table's range.
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.status == ntcf_pkg::STATUS_NEW
                         || o_out.status == ntcf_pkg::STATUS_HELD))
            |-> (o_out.temperature_centi >= -16'sd20000
                 && o_out.temperature_centi <= 16'sd30000))
        else $error("reported temperature outside the table range");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("result changed while stalled");

endmodule

bind ntc_temperature_filter_unit ntcf_checker u_ntcf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
`default_nettype wire

// File: tb/sv/ntc_temperature_filter_unit_test.sv
`timescale 1ns / 1ps
// ============================================================================
// NTC temperature filter unit testbench
// Sends thermistor readings through the valid/ready input channel, rebuilds
// the conversion table from its fixed-point formula and predicts every result
// item, including clamping, slew limiting and per-channel history. A directed
// table comes first, then random phases with new clamp and step settings.
// ============================================================================
module ntc_temperature_filter_unit_test;

    // Cycles with no accepted item on either channel before the run is abandoned.
    localparam int QUIET_LIMIT = 2000;

    // Per-phase stimulus sizes. The last two random phases run without idling.
    localparam int RANDOM_PHASES    = 8;
    localparam int PHASE_ITEMS      = 125;
    localparam int IDLE_FREE_PHASES = 2;

    // One line of the directed table: either a register write or a reading,
    // with a result typed in only where it is obvious.
    typedef struct {
        bit              is_write;
        logic [1:0]      reg_idx;
        logic [15:0]     reg_data;
        ntcf_pkg::t_in   reading;
        bit              has_known;
        ntcf_pkg::t_out  known_res;
    } t_plan_row;

    logic            i_clk      = 1'b0;
    logic            i_rst_n    = 1'b0;
    logic            i_in_valid = 1'b0;
    ntcf_pkg::t_in   i_in       = '0;
    logic            i_out_ready = 1'b0;
    logic            i_cfg_we   = 1'b0;
    logic [1:0]      i_cfg_idx  = '0;
    logic [15:0]     i_cfg_data = '0;
    logic            o_in_ready;
    logic            o_out_valid;
    ntcf_pkg::t_out  o_out;

    // Mirror of the block's state used by the predictor.
    int                 conv_temp [1024];
    bit                 conv_ok   [1024];
    int                 cfg_lo   = -2000;
    int                 cfg_hi   = 10000;
    int                 cfg_step = 1500;
    logic signed [15:0] hist_temp [4];
    bit                 hist_ok   [4];

    ntcf_pkg::t_out expected_temps [$];
    t_plan_row      directed_plan [$];

    bit gaps_on   = 1'b1;
    bit stalls_on = 1'b1;
    int stall_left = 0;
    int quiet_cycles = 0;
    int fail_count = 0;

    ntc_temperature_filter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // 4 ns clock period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Base-two logarithm in Q28. The integer part is the position of the
    // leading one; each fraction bit comes from squaring a Q30 mantissa and
    // checking whether it passed 2.0.
    function automatic longint unsigned log2_fixed(input longint unsigned x);
        longint unsigned mant;
        longint unsigned frac;
        longint unsigned msb;
        int              bitpos;
        msb = 0;
        while ((x >> (msb + 1)) != 0) begin
            msb++;
        end
        mant = x << (30 - msb);
        frac = 0;
        for (bitpos = 27; bitpos >= 0; bitpos--) begin
            mant = (mant * mant) >> 30;
            if (mant >= (64'd1 << 31)) begin
                mant = mant >> 1;
                frac = frac | (64'd1 << bitpos);
            end
        end
        return (msb << 28) | frac;
    endfunction

    // Fill the conversion table: divider resistance from the averaged code,
    // then the Steinhart-Hart polynomial in ln R and a rounded reciprocal.
    task automatic build_conversion_table();
        longint unsigned code;
        longint unsigned lg_hi;
        longint unsigned lg_lo;
        longint unsigned ln_r;
        longint unsigned ln_24;
        longint unsigned ln_sq;
        longint unsigned ln_cube;
        longint unsigned denom;
        longint          centi;
        for (code = 0; code < 1024; code++) begin
            conv_temp[code] = 0;
            conv_ok[code]   = 1'b0;
            // Zero code, divider within 1/300 of full scale, or under 100 ohm.
            if (code != 0 && 300 * code < 299 * 1024 && 101 * code >= 1024) begin
                lg_hi = log2_fixed(10000 * code);
                lg_lo = log2_fixed(1024 - code);
                if (lg_hi > lg_lo) begin
                    ln_r    = ((lg_hi - lg_lo) * 64'd744261118) >> 30;
                    ln_24   = ln_r >> 4;
                    ln_sq   = (ln_24 * ln_24) >> 24;
                    ln_cube = (ln_sq * ln_24) >> 24;
                    denom   = 64'd2775575000 + ((64'd248040000 * ln_r) >> 28)
                            + ((64'd490786 * ln_cube) >> 24);
                    centi   = longint'((64'd200000000000000 + denom) / (2 * denom))
                            - 27315;
                    if (centi >= -20000 && centi <= 30000) begin
                        conv_temp[code] = int'(centi);
                        conv_ok[code]   = 1'b1;
                    end
                end
            end
        end
    endtask

    // Predict the result item for one accepted reading and update the
    // channel history the same way the block does.
    function automatic ntcf_pkg::t_out filter_reading(input ntcf_pkg::t_in rd);
        ntcf_pkg::t_out res;
        int             sum;
        int             idx;
        int             val;
        int             prev;
        sum = int'(rd.sample_a) + int'(rd.sample_b) + int'(rd.sample_c)
            + int'(rd.sample_d);
        idx = sum / 4;
        res.chan_out          = rd.chan;
        res.temperature_centi = '0;
        res.status            = ntcf_pkg::STATUS_NONE;
        if (conv_ok[idx]) begin
            val = conv_temp[idx];
            // The lower bound is tested first, so it wins for values below it when min > max.
            if (val < cfg_lo) begin
                val = cfg_lo;
            end else if (val > cfg_hi) begin
                val = cfg_hi;
            end
            if (hist_ok[rd.chan]) begin
                prev = int'(hist_temp[rd.chan]);
                if (val > prev + cfg_step) begin
                    val = prev + cfg_step;
                end else if (val < prev - cfg_step) begin
                    val = prev - cfg_step;
                end
            end
            hist_temp[rd.chan]    = 16'(val);
            hist_ok[rd.chan]      = 1'b1;
            res.temperature_centi = 16'(val);
            res.status            = ntcf_pkg::STATUS_NEW;
        end else if (hist_ok[rd.chan]) begin
            res.temperature_centi = hist_temp[rd.chan];
            res.status            = ntcf_pkg::STATUS_HELD;
        end
        return res;
    endfunction

    task automatic plan_item(input logic [1:0] ch, input logic [9:0] sa,
                             input logic [9:0] sb, input logic [9:0] sc,
                             input logic [9:0] sd, input bit has_known,
                             input int temp, input logic [1:0] status);
        t_plan_row row;
        row.is_write  = 1'b0;
        row.reg_idx   = '0;
        row.reg_data  = '0;
        row.reading   = '{chan: ch, sample_a: sa, sample_b: sb, sample_c: sc,
                          sample_d: sd};
        row.has_known = has_known;
        row.known_res = '{chan_out: ch, temperature_centi: 16'(temp), status: status};
        directed_plan.push_back(row);
    endtask

    task automatic plan_write(input logic [1:0] idx, input int data);
        t_plan_row row;
        row.is_write  = 1'b1;
        row.reg_idx   = idx;
        row.reg_data  = 16'(data);
        row.reading   = '0;
        row.has_known = 1'b0;
        row.known_res = '0;
        directed_plan.push_back(row);
    endtask

    // Present one reading, hold it until the handshake, then record what
    // the block should answer. Sometimes the sender idles first.
    task automatic send_reading(input ntcf_pkg::t_in rd, input bit has_known,
                                input ntcf_pkg::t_out known);
        ntcf_pkg::t_out pred;
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= rd;
        do @(posedge i_clk); while (!o_in_ready);
        pred = filter_reading(rd);
        expected_temps.push_back(has_known ? known : pred);
    endtask

    // Stop sending and wait until every expected result item has come out,
    // then let the three-stage pipeline settle.
    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_temps.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write one register and mirror it in the predictor. The enable drops on
    // the following cycle, so back-to-back writes never collide.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            ntcf_pkg::CFG_TEMP_MIN: begin
                cfg_lo = int'($signed(data));
            end
            ntcf_pkg::CFG_TEMP_MAX: begin
                cfg_hi = int'($signed(data));
            end
            ntcf_pkg::CFG_MAX_STEP: begin
                cfg_step = int'(data[14:0]);
            end
            default: begin
            end
        endcase
        @(posedge i_clk);
    endtask

    // Clamp limits favor the ends of the legal range now and then.
    function automatic int pick_limit();
        case ($urandom_range(0, 3))
            0: return -20000;
            1: return 30000;
            default: return int'($urandom_range(0, 50000)) - 20000;
        endcase
    endfunction

    // Result receiver: stalls come in random bursts.
    always @(posedge i_clk) begin
        if (!stalls_on) begin
            i_out_ready <= 1'b1;
            stall_left  <= 0;
        end else if (stall_left != 0) begin
            i_out_ready <= (stall_left == 1);
            stall_left  <= stall_left - 1;
        end else if ($urandom_range(0, 11) == 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= $urandom_range(1, 16);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Result checker: every accepted result item is matched against the
    // oldest prediction, field by field.
    always @(posedge i_clk) begin : check_result
        ntcf_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_temps.size() == 0) begin
                $error("unexpected result item: chan_out %0d temperature_centi %0d",
                       o_out.chan_out, $signed(o_out.temperature_centi));
                fail_count++;
            end else begin
                want = expected_temps.pop_front();
                if (o_out.chan_out !== want.chan_out) begin
                    $error("chan_out: expected %0d, got %0d",
                           want.chan_out, o_out.chan_out);
                    fail_count++;
                end
                if (o_out.temperature_centi !== want.temperature_centi) begin
                    $error("temperature_centi: expected %0d, got %0d",
                           $signed(want.temperature_centi),
                           $signed(o_out.temperature_centi));
                    fail_count++;
                end
                if (o_out.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out.status);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: a run that stops moving items for too long has hung.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("ntc_temperature_filter_unit_test NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        t_plan_row     row;
        ntcf_pkg::t_in rd;
        bit            prev_write;
        int            drift_base [4];
        int            lo;
        int            hi;
        int            swap;
        int            kind;
        int            base;
        int            val;
        int            step_sel;
        logic [9:0]    smp [4];

        build_conversion_table();
        foreach (hist_ok[c]) begin
            hist_ok[c]   = 1'b0;
            hist_temp[c] = '0;
            drift_base[c] = $urandom_range(0, 1023);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table. Right after reset no channel has a stored value, so
        // an invalid table entry reads back as "no value yet" with zero.
        plan_item(0, 0, 0, 0, 0, 1, 0, ntcf_pkg::STATUS_NONE);              // zero code
        plan_item(1, 1023, 1023, 1023, 1023, 1, 0, ntcf_pkg::STATUS_NONE);  // full scale
        plan_item(2, 10, 10, 10, 10, 1, 0, ntcf_pkg::STATUS_NONE);          // under 100 ohm
        plan_item(3, 1021, 1021, 1021, 1021, 1, 0, ntcf_pkg::STATUS_NONE);  // near the rail
        plan_item(3, 1, 2, 3, 5, 1, 0, ntcf_pkg::STATUS_NONE);    // average truncates to 2
        // The coldest valid code on an empty channel lands on the reset minimum.
        plan_item(1, 1020, 1020, 1020, 1020, 1, -2000, ntcf_pkg::STATUS_NEW);
        plan_item(0, 11, 11, 11, 11, 0, 0, ntcf_pkg::STATUS_NEW);        // lowest valid code
        plan_item(0, 0, 0, 0, 0, 0, 0, ntcf_pkg::STATUS_HELD);           // held value
        plan_item(2, 1023, 1023, 1023, 0, 0, 0, ntcf_pkg::STATUS_NEW);   // averages to 767
        plan_item(2, 341, 682, 341, 682, 0, 0, ntcf_pkg::STATUS_NEW);    // alternating bits
        plan_item(3, 512, 512, 512, 512, 0, 0, ntcf_pkg::STATUS_NEW);
        plan_item(3, 1023, 1023, 1023, 1023, 0, 0, ntcf_pkg::STATUS_HELD);
        // Widest window with a zero step: every stored value is frozen.
        plan_write(ntcf_pkg::CFG_MAX_STEP, 0);
        plan_write(ntcf_pkg::CFG_TEMP_MIN, -20000);
        plan_write(ntcf_pkg::CFG_TEMP_MAX, 30000);
        plan_item(0, 1020, 1020, 1020, 1020, 0, 0, ntcf_pkg::STATUS_NEW);
        plan_item(1, 512, 512, 512, 512, 0, 0, ntcf_pkg::STATUS_NEW);
        // Largest step: readings pass straight through the window.
        plan_write(ntcf_pkg::CFG_MAX_STEP, 30000);
        plan_item(1, 1020, 1020, 1020, 1020, 0, 0, ntcf_pkg::STATUS_NEW);
        plan_item(2, 11, 11, 11, 11, 0, 0, ntcf_pkg::STATUS_NEW);
        plan_item(3, 1023, 0, 1023, 0, 0, 0, ntcf_pkg::STATUS_NEW);
        // Minimum above maximum: low readings go to the minimum, the rest to
        // the maximum.
        plan_write(ntcf_pkg::CFG_TEMP_MIN, -5000);
        plan_write(ntcf_pkg::CFG_TEMP_MAX, -18000);
        plan_item(0, 11, 11, 11, 11, 0, 0, ntcf_pkg::STATUS_NEW);
        plan_item(1, 1020, 1020, 1020, 1020, 0, 0, ntcf_pkg::STATUS_NEW);
        plan_item(2, 512, 512, 512, 512, 0, 0, ntcf_pkg::STATUS_NEW);

        prev_write = 1'b0;
        foreach (directed_plan[k]) begin
            row = directed_plan[k];
            if (row.is_write) begin
                if (!prev_write) begin
                    drain_pipeline();
                end
                write_reg(row.reg_idx, row.reg_data);
            end else begin
                send_reading(row.reading, row.has_known, row.known_res);
            end
            prev_write = row.is_write;
        end

        // Random phases. Each starts from an empty pipeline with new settings.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_pipeline();
            lo = pick_limit();
            hi = pick_limit();
            // Mostly an ordered window, sometimes an inverted one.
            if (lo > hi && $urandom_range(0, 3) != 0) begin
                swap = lo;
                lo   = hi;
                hi   = swap;
            end
            step_sel = $urandom_range(0, 5);
            write_reg(ntcf_pkg::CFG_TEMP_MIN, 16'(lo));
            write_reg(ntcf_pkg::CFG_TEMP_MAX, 16'(hi));
            write_reg(ntcf_pkg::CFG_MAX_STEP, (step_sel == 0) ? 16'd0 :
                                    (step_sel == 1) ? 16'd30000 :
                                    (step_sel == 2) ? 16'($urandom_range(0, 30000)) :
                                    16'($urandom_range(0, 3000)));
            if (ph < RANDOM_PHASES - IDLE_FREE_PHASES) begin
                gaps_on   = ($urandom_range(0, 3) != 0);
                stalls_on = ($urandom_range(0, 3) != 0);
            end else begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end

            repeat (PHASE_ITEMS) begin
                rd.chan = 2'($urandom_range(0, 3));
                kind    = $urandom_range(0, 99);
                if (kind < 40) begin
                    // A channel's temperature wanders slowly, as a real one
                    // would, so slew limiting sees small and large moves.
                    val = drift_base[rd.chan] + int'($urandom_range(0, 40)) - 20;
                    drift_base[rd.chan] = (val < 0) ? 0 : (val > 1023) ? 1023 : val;
                    base = drift_base[rd.chan];
                end else begin
                    base = $urandom_range(0, 1023);
                end
                for (int s = 0; s < 4; s++) begin
                    if (kind < 70) begin
                        val = base + int'($urandom_range(0, 16)) - 8;
                        smp[s] = (val < 0) ? 10'd0 : (val > 1023) ? 10'd1023 : 10'(val);
                    end else if (kind < 85) begin
                        smp[s] = 10'($urandom_range(0, 1023));
                    end else begin
                        case ($urandom_range(0, 6))
                            0: smp[s] = 10'd0;
                            1: smp[s] = 10'd1023;
                            2: smp[s] = 10'd10;
                            3: smp[s] = 10'd11;
                            4: smp[s] = 10'd1020;
                            5: smp[s] = 10'd1021;
                            default: smp[s] = 10'($urandom_range(0, 1023));
                        endcase
                    end
                end
                rd.sample_a = smp[0];
                rd.sample_b = smp[1];
                rd.sample_c = smp[2];
                rd.sample_d = smp[3];
                send_reading(rd, 1'b0, '0);
            end
        end

        // Let the last result items out, then keep watching in case the
        // block produces anything it should not.
        i_in_valid <= 1'b0;
        while (expected_temps.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ntc_temperature_filter_unit_test OK");
        end else begin
            $display("ntc_temperature_filter_unit_test NOT OK");
        end
        $finish;
    end

endmodule
